FILE: rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared codes of the stripe lock table
// request opcodes and result status codes
// ----------------------------------------------------------------------------
package slt_pkg;

  typedef enum logic [1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_MODE   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CHANGING = 3'd1,
    ST_HELD     = 3'd2,
    ST_FULL     = 3'd3,
    ST_MODE_BAD = 3'd4,
    ST_BUSY     = 3'd5
  } status_t;

  localparam int unsigned COUNT_W = 7;

endpackage

FILE: rtl/slt_channels.sv
// ----------------------------------------------------------------------------
// slt channels: request and response interfaces
// valid/ready channels carrying one lock table request or one result
// ----------------------------------------------------------------------------
interface slt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] stripe_id;
  logic        requested_mode;

  modport source (output valid, output op, output stripe_id, output requested_mode,
                  input ready);
  modport sink   (input valid, input op, input stripe_id, input requested_mode,
                  output ready);
endinterface

interface slt_rsp_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic [2:0] status;
  logic [6:0] held_count;

  modport source (output valid, output success, output status, output held_count,
                  input ready);
  modport sink   (input valid, input success, input status, input held_count,
                  output ready);
endinterface

FILE: rtl/stripe_lock_table.sv
// ----------------------------------------------------------------------------
// stripe_lock_table: content-addressed table of held stripe numbers
// grants, refuses and releases stripe locks and checks mode changes
// ----------------------------------------------------------------------------
// usage
//   in_ch  : request transfer (op, stripe_id, requested_mode), valid/ready
//   out_ch : one result transfer per request (success, status, held_count)
//   cfg_we / cfg_wdata : write of the state_changing flag, only while idle
// timing
//   a request transferred into the input register is looked up against all
//   entries there and its result is registered in the result register,
//   which drives out_ch.valid
//   one request per cycle is sustained while out_ch.ready is high; the rate
//   is set by the combinational parallel compare over every entry plus the
//   lowest-free-slot pick feeding the entry registers
// reset
//   rst_n low clears all valid bits, the held count, the flag and both
//   pipeline valids; stored stripe numbers are not cleared
// stall
//   when out_ch.ready is low the result stays put; one more request waits
//   in the input register, after which in_ch.ready drops
// ----------------------------------------------------------------------------
module stripe_lock_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  slt_req_if.sink   in_ch,
  slt_rsp_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import slt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // configuration
  logic changing_r;

  // input register
  logic        stage_v_r;
  logic [1:0]  op_r;
  logic [31:0] id_r;
  logic        mode_r;

  // table entries
  logic [31:0]            ids_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] valid_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;

  // result register
  logic         out_v_r;
  logic         success_r;
  logic [2:0]   status_r;
  logic [6:0]   held_r;

  // lookup
  logic [TABLE_DEPTH-1:0] match;
  logic [TABLE_DEPTH-1:0] free;
  logic [TABLE_DEPTH-1:0] pick;
  logic [TABLE_DEPTH-1:0] set_mask;
  logic [TABLE_DEPTH-1:0] clr_mask;
  logic                   hit;
  logic                   full;
  logic                   ok;
  status_t                status;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  logic in_xfer;
  logic move;

  // the item in the input register moves on when the result slot frees up
  assign move     = stage_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !stage_v_r || move;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changing_r <= 1'b0;
    end else if (cfg_we) begin
      changing_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_xfer) begin
      stage_v_r <= 1'b1;
    end else if (move) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_ch.op;
      id_r   <= in_ch.stripe_id;
      mode_r <= in_ch.requested_mode;
    end
  end

  // parallel compare against every held entry; ids are unique so at most one hits
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = valid_r[i] && (ids_r[i] == id_r);
    end
  end

  assign hit  = |match;
  assign free = ~valid_r;
  assign full = ~|free;
  // isolate the lowest free slot
  assign pick = free & (~free + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});

  always_comb begin
    ok       = 1'b0;
    status   = ST_OK;
    set_mask = '0;
    clr_mask = '0;
    cnt_nxt  = cnt_r;
    case (op_r)
      OP_LOCK: begin
        // flag beats already locked, which beats table full
        if (changing_r) begin
          status = ST_CHANGING;
        end else if (hit) begin
          status = ST_HELD;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ok       = 1'b1;
          set_mask = pick;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end
      OP_UNLOCK: begin
        // unlock of an absent stripe still reports success
        ok = 1'b1;
        if (hit) begin
          clr_mask = match;
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      OP_MODE: begin
        if (mode_r) begin
          status = ST_MODE_BAD;
        end else if (cnt_r != '0) begin
          status = ST_BUSY;
        end else begin
          ok = 1'b1;
        end
      end
      default: begin
        // unused opcode: no effect, success low with status ST_OK
        ok     = 1'b0;
        status = ST_OK;
      end
    endcase
  end

  assign valid_nxt = (valid_r | set_mask) & ~clr_mask;
  // held count is reported modulo the 7-bit field
  assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (move) begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (move && set_mask[i]) begin
        ids_r[i] <= id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (move) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      success_r <= ok;
      status_r  <= status;
      held_r    <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.success    = success_r;
  assign out_ch.status     = status_r;
  assign out_ch.held_count = held_r;

  // counter tracks the number of valid entries
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == cnt_r)
    else $error("held count differs from valid entries");

  // a granted lock occupies exactly one more slot
  a_grant_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (move && ok && op_r == OP_LOCK) |=>
      $countones(valid_r) == $countones($past(valid_r)) + 1)
    else $error("lock grant did not take exactly one slot");

  // table full is only reported when every slot is taken
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (move && status == ST_FULL) |-> (&valid_r))
    else $error("table full reported with a free slot");

  // a successful result always carries the ok status
  a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && success_r) |-> (status_r == ST_OK))
    else $error("success with a non-ok status");

endmodule
